// ----- sv/utrb_pkg.sv -----
// types, constants and command codes shared by the uart ring buffer unit
// no dependencies; imported by utrb_ring and uart_tx_rx_ring_buffers_unit
package utrb_pkg;

    localparam int BUF_DEPTH = 16;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = 4;
    localparam int OCC_W     = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;

    localparam logic [1:0] CMD_HOST_WRITE = 2'd0;
    localparam logic [1:0] CMD_HOST_READ  = 2'd1;
    localparam logic [1:0] CMD_LINE_RX    = 2'd2;
    localparam logic [1:0] CMD_TX_READY   = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       read_data;
        logic             read_valid;
        logic [7:0]       line_byte;
        logic             line_valid;
        logic             write_refused;
        logic             transmit_irq_enabled;
        logic [CNT_W-1:0] receive_waiting;
        logic [CNT_W-1:0] transmit_used;
        logic [15:0]      receive_overrun_total;
        logic [15:0]      transmit_refusal_total;
    } result_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic drop;
    } ring_ctrl_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
    } ring_status_t;

endpackage

// ----- sv/utrb_ring.sv -----
// one byte ring buffer: register file, head and tail pointers, occupancy
// depends on utrb_pkg
module utrb_ring (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  utrb_pkg::ring_ctrl_t  ctrl,
    input  logic [7:0]            wr_data,
    output logic [7:0]            rd_data,
    output utrb_pkg::ring_status_t status
);
    import utrb_pkg::*;

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [7:0]       mem [BUF_DEPTH];
    logic [OCC_W-1:0] occ;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.empty = (head_reg == tail_reg);
    assign status.full  = (wrap_inc(tail_reg) == head_reg);
    assign rd_data      = mem[head_reg];

    assign head_next = (ctrl.pop || ctrl.drop) ? wrap_inc(head_reg) : head_reg;
    assign tail_next = ctrl.push ? wrap_inc(tail_reg) : tail_reg;

    // occupancy after this transaction
    always_comb begin
        if (tail_next >= head_next) begin
            occ = OCC_W'(tail_next) - OCC_W'(head_next);
        end else begin
            occ = OCC_W'(tail_next) + OCC_W'(BUF_DEPTH) - OCC_W'(head_next);
        end
    end
    assign status.count = occ[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem[tail_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/uart_tx_rx_ring_buffers_unit.sv -----
// top level of the uart ring buffer pair: input register, command decode, result register
// depends on utrb_pkg and utrb_ring
//
// A host write, host read, received line byte or transmitter-ready event enters
// on s_item and yields exactly one result on m_result. An item is held in the input
// register and is decoded against both rings in a single pass into the result
// register, so one item per cycle is sustained when m_ready is high. Each ring
// holds BUF_DEPTH-1 bytes. A host write to a full transmit ring is refused and
// counted; a received byte on a full receive ring overwrites the oldest byte and
// is counted as an overrun. Occupancy fields report the count modulo 16. No
// clearing pass follows reset.
module uart_tx_rx_ring_buffers_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  utrb_pkg::in_item_t s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output utrb_pkg::result_t  m_result
);
    import utrb_pkg::*;

    logic         in_vld_reg;
    in_item_t     in_item_reg;
    logic         out_vld_reg;
    result_t      out_result_reg;
    logic         irq_reg, irq_next;
    logic [15:0]  ovr_cnt_reg, ovr_cnt_next;
    logic [15:0]  ref_cnt_reg, ref_cnt_next;
    logic         advance;
    logic         refused;
    ring_ctrl_t   tx_ctrl, rx_ctrl;
    ring_status_t tx_status, rx_status;
    logic [7:0]   tx_rd, rx_rd;
    result_t      res;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_result = out_result_reg;

    utrb_ring u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .wr_data (in_item_reg.data_byte),
        .rd_data (tx_rd),
        .status  (tx_status)
    );

    utrb_ring u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .wr_data (in_item_reg.data_byte),
        .rd_data (rx_rd),
        .status  (rx_status)
    );

    always_comb begin
        tx_ctrl   = '0;
        rx_ctrl   = '0;
        irq_next  = irq_reg;
        refused   = 1'b0;
        res       = '0;
        if (advance) begin
            case (in_item_reg.command)
                CMD_HOST_WRITE: begin
                    if (tx_status.full) begin
                        refused = 1'b1;
                    end else begin
                        tx_ctrl.push = 1'b1;
                        irq_next     = 1'b1;
                    end
                end
                CMD_HOST_READ: begin
                    if (!rx_status.empty) begin
                        rx_ctrl.pop    = 1'b1;
                        res.read_valid = 1'b1;
                        res.read_data  = rx_rd;
                    end
                end
                CMD_LINE_RX: begin
                    rx_ctrl.push = 1'b1;
                    rx_ctrl.drop = rx_status.full;
                end
                default: begin
                    if (!tx_status.empty) begin
                        tx_ctrl.pop    = 1'b1;
                        res.line_valid = 1'b1;
                        res.line_byte  = tx_rd;
                    end else begin
                        irq_next = 1'b0;
                    end
                end
            endcase
        end
        ovr_cnt_next = ovr_cnt_reg + 16'(rx_ctrl.drop);
        ref_cnt_next = ref_cnt_reg + 16'(refused);
        res.write_refused          = refused;
        res.transmit_irq_enabled   = irq_next;
        res.receive_waiting        = rx_status.count;
        res.transmit_used          = tx_status.count;
        res.receive_overrun_total  = ovr_cnt_next;
        res.transmit_refusal_total = ref_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            irq_reg     <= 1'b0;
            ovr_cnt_reg <= '0;
            ref_cnt_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            irq_reg     <= irq_next;
            ovr_cnt_reg <= ovr_cnt_next;
            ref_cnt_reg <= ref_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= res;
        end
    end

    // at most one byte leaves the rings per transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_result.read_valid && m_result.line_valid))
        else $error("read and line byte in one result");

    // refused write moves no data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.write_refused |-> !m_result.read_valid && !m_result.line_valid)
        else $error("refused write carries data");

    // interrupt enable only drops once the transmit ring has drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.transmit_irq_enabled |-> m_result.transmit_used == '0)
        else $error("transmit enable clear with bytes queued");

    // refusal counter steps by one on each refused write
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && refused |=> ref_cnt_reg == $past(ref_cnt_reg) + 16'd1)
        else $error("refusal count not advanced");

    // results are produced only from a held item
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> in_vld_reg && s_ready)
        else $error("result without input item");

endmodule
